// ----- hdl/string_bucket_hash_unit_macros.svh -----
`ifndef STRING_BUCKET_HASH_UNIT_MACROS_SVH
`define STRING_BUCKET_HASH_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SBH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SBH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/sbh_pkg.sv -----
`timescale 1ns / 1ps

package sbh_pkg;

    localparam int unsigned SBH_WORD_W   = 32;
    localparam logic [31:0] SBH_GOLDEN   = 32'h9e3779b9;
    localparam logic [31:0] SBH_TS_RESET = 32'd1024;
    localparam logic [3:0]  SBH_GROUP_LAST = 4'd11;
    localparam logic [3:0]  SBH_MIX_LAST   = 4'd8;

    typedef struct packed {
        logic                  start;
        logic [SBH_WORD_W-1:0] dividend;
        logic [SBH_WORD_W-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic                  done;
        logic [SBH_WORD_W-1:0] remainder;
    } mod_rsp_t;

    function automatic logic [4:0] sbh_mix_shift(input logic [3:0] step);
        logic [4:0] amt;
        begin
            case (step)
                4'd0:    amt = 5'd13;
                4'd1:    amt = 5'd8;
                4'd2:    amt = 5'd13;
                4'd3:    amt = 5'd12;
                4'd4:    amt = 5'd16;
                4'd5:    amt = 5'd5;
                4'd6:    amt = 5'd3;
                4'd7:    amt = 5'd10;
                4'd8:    amt = 5'd15;
                default: amt = 5'd0;
            endcase
            return amt;
        end
    endfunction

endpackage

// ----- hdl/string_bucket_hash_unit.sv -----
`timescale 1ns / 1ps
`include "string_bucket_hash_unit_macros.svh"

// channel   handshake                 payload
// data      data_valid / data_stall   data_byte, last
// bucket    bucket_valid / bucket_stall bucket
// cfg       cfg_valid / cfg_ready     table_size
//
// one byte per cycle while data_stall is low; every twelfth byte adds mixing, steps 0 to 8 (one mix step a cycle)
// a last byte runs the mix steps, then the serial remainder unit, then the output state
// reset: table_size 1024, words seeded, no bucket pending
// a finished bucket waits in an output register; data_stall is high while mixing,
// dividing, while a table_size write is offered, or while a new bucket cannot yet
// enter the output register

module string_bucket_hash_unit
    import sbh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_stall,
    input  logic [7:0]  data_byte,
    input  logic        last,
    output logic        bucket_valid,
    input  logic        bucket_stall,
    output logic [31:0] bucket,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] table_size
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MIX  = 2'd1;
    localparam logic [1:0] ST_MOD  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    localparam logic [1:0] ROLE_A = 2'd0;
    localparam logic [1:0] ROLE_B = 2'd1;
    localparam logic [1:0] ROLE_C = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [3:0]  step_reg, step_next;
    logic [1:0]  role_reg, role_next;
    logic        final_reg, final_next;
    logic [3:0]  count_reg, count_next;
    logic [31:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic [31:0] c_reg, c_next;
    logic [31:0] modulus_reg, modulus_next;
    logic        small_reg, small_next;
    logic [7:0]  tail_reg [3];
    logic [7:0]  tail_next [3];
    logic [31:0] res_reg, res_next;
    logic [31:0] bucket_reg, bucket_next;
    logic        bucket_valid_reg, bucket_valid_next;

    logic [31:0] lane;
    logic [31:0] tail_word;
    logic [7:0]  m8, m9, m10;
    logic [31:0] mt, mx, my, diff, shifted, mix_res;
    logic [4:0]  amt;
    mod_req_t    mod_req;
    mod_rsp_t    mod_rsp;

    sbh_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    assign data_stall   = (state_reg != ST_IDLE) || cfg_valid;
    assign cfg_ready    = (state_reg == ST_IDLE);
    assign bucket_valid = bucket_valid_reg;
    assign bucket       = bucket_reg;

    // byte placed in its lane of the word
    assign lane = 32'(data_byte) << {count_reg[1:0], 3'b000};

    // tail count in the low byte, tail bytes 8 to 10 from bit 8 up
    assign m8        = (count_reg >= 4'd9)  ? tail_reg[0] : 8'd0;
    assign m9        = (count_reg >= 4'd10) ? tail_reg[1] : 8'd0;
    assign m10       = (count_reg >= 4'd11) ? tail_reg[2] : 8'd0;
    assign tail_word = {m10, m9, m8, 4'b0000, count_reg};

    // shared mix step: t = (t - x - y) ^ shift(y)
    always_comb
    begin
        case (role_reg)
            ROLE_A:
            begin
                mt = a_reg; mx = b_reg; my = c_reg;
            end
            ROLE_B:
            begin
                mt = b_reg; mx = c_reg; my = a_reg;
            end
            default:
            begin
                mt = c_reg; mx = a_reg; my = b_reg;
            end
        endcase
    end

    assign amt     = sbh_mix_shift(step_reg);
    assign diff    = mt - mx - my;
    assign shifted = (role_reg == ROLE_B) ? (my << amt) : (my >> amt);
    assign mix_res = diff ^ shifted;

    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        role_next         = role_reg;
        final_next        = final_reg;
        count_next        = count_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        c_next            = c_reg;
        modulus_next      = modulus_reg;
        small_next        = small_reg;
        tail_next         = tail_reg;
        res_next          = res_reg;
        bucket_next       = bucket_reg;
        bucket_valid_next = bucket_valid_reg;

        mod_req.start    = 1'b0;
        mod_req.dividend = mix_res;
        mod_req.divisor  = modulus_reg;

        if (bucket_valid_reg && !bucket_stall)
        begin
            bucket_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            modulus_next = table_size - 32'd1;
            small_next   = (table_size < 32'd2);
            a_next       = SBH_GOLDEN;
            b_next       = SBH_GOLDEN;
            c_next       = table_size - 32'd1;
            count_next   = '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (data_valid)
                    begin
                        step_next = '0;
                        role_next = ROLE_A;
                        if (last)
                        begin
                            c_next     = c_reg + tail_word;
                            count_next = '0;
                            final_next = 1'b1;
                            state_next = ST_MIX;
                        end
                        else if (count_reg == SBH_GROUP_LAST)
                        begin
                            c_next     = c_reg + {data_byte, tail_reg[2], tail_reg[1],
                                                  tail_reg[0]};
                            count_next = '0;
                            final_next = 1'b0;
                            state_next = ST_MIX;
                        end
                        else
                        begin
                            count_next = count_reg + 4'd1;
                            if (count_reg < 4'd4)
                            begin
                                a_next = a_reg + lane;
                            end
                            else if (count_reg < 4'd8)
                            begin
                                b_next = b_reg + lane;
                            end
                            else
                            begin
                                case (count_reg[1:0])
                                    2'd0:    tail_next[0] = data_byte;
                                    2'd1:    tail_next[1] = data_byte;
                                    default: tail_next[2] = data_byte;
                                endcase
                            end
                        end
                    end
                end
                ST_MIX:
                begin
                    case (role_reg)
                        ROLE_A:  a_next = mix_res;
                        ROLE_B:  b_next = mix_res;
                        default: c_next = mix_res;
                    endcase
                    if (step_reg == SBH_MIX_LAST)
                    begin
                        step_next = '0;
                        role_next = ROLE_A;
                        if (final_reg)
                        begin
                            mod_req.start = 1'b1;
                            state_next    = ST_MOD;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        step_next = step_reg + 4'd1;
                        role_next = (role_reg == ROLE_C) ? ROLE_A : role_reg + 2'd1;
                    end
                end
                ST_MOD:
                begin
                    if (mod_rsp.done)
                    begin
                        res_next   = small_reg ? 32'd0 : mod_rsp.remainder + 32'd1;
                        state_next = ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!bucket_valid_reg || !bucket_stall)
                    begin
                        bucket_next       = res_reg;
                        bucket_valid_next = 1'b1;
                        a_next            = SBH_GOLDEN;
                        b_next            = SBH_GOLDEN;
                        c_next            = modulus_reg;
                        count_next        = '0;
                        state_next        = ST_IDLE;
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            role_reg         <= ROLE_A;
            final_reg        <= 1'b0;
            count_reg        <= '0;
            a_reg            <= SBH_GOLDEN;
            b_reg            <= SBH_GOLDEN;
            c_reg            <= SBH_TS_RESET - 32'd1;
            modulus_reg      <= SBH_TS_RESET - 32'd1;
            small_reg        <= 1'b0;
            bucket_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            role_reg         <= role_next;
            final_reg        <= final_next;
            count_reg        <= count_next;
            a_reg            <= a_next;
            b_reg            <= b_next;
            c_reg            <= c_next;
            modulus_reg      <= modulus_next;
            small_reg        <= small_next;
            bucket_valid_reg <= bucket_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tail_reg   <= tail_next;
        res_reg    <= res_next;
        bucket_reg <= bucket_next;
    end

    `SBH_ASSERT_NEXT(a_mod_after_mix, state_reg == ST_MIX && step_reg == SBH_MIX_LAST && final_reg, state_reg == ST_MOD, "final mix did not start remainder")
    `SBH_ASSERT_NOW(a_count_range, state_reg != ST_IDLE, count_reg == 4'd0 || state_reg == ST_OUT, "byte count not cleared after group")
    `SBH_ASSERT_NOW(a_load_from_out, $rose(bucket_valid_reg), $past(state_reg) == ST_OUT, "bucket loaded outside output state")
    `SBH_ASSERT_NOW(a_step_range, state_reg == ST_MIX, step_reg <= SBH_MIX_LAST, "mix step out of range")

endmodule

// ----- hdl/sbh_mod.sv -----
`timescale 1ns / 1ps
`include "string_bucket_hash_unit_macros.svh"

module sbh_mod
    import sbh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mod_req_t req,
    output mod_rsp_t rsp
);

    localparam int unsigned CNT_W = $clog2(SBH_WORD_W);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [SBH_WORD_W-1:0] rem_reg, rem_next;
    logic [SBH_WORD_W-1:0] dvd_reg, dvd_next;
    logic [SBH_WORD_W:0]   trial;

    // one remainder bit per cycle, restoring form
    assign trial = {rem_reg, dvd_reg[SBH_WORD_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = req.dividend;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, req.divisor})
            begin
                rem_next = SBH_WORD_W'(trial - {1'b0, req.divisor});
            end
            else
            begin
                rem_next = trial[SBH_WORD_W-1:0];
            end
            dvd_next = {dvd_reg[SBH_WORD_W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(SBH_WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

    `SBH_ASSERT_NOW(a_rem_below_divisor, rsp.done && req.divisor != '0, rsp.remainder < req.divisor, "remainder not below divisor")
    `SBH_ASSERT_NOW(a_no_start_busy, req.start, !busy_reg, "start while busy")
    `SBH_ASSERT_NEXT(a_done_pulse, done_reg, !done_reg && !busy_reg, "done longer than one cycle")

endmodule
